// ===== rtl/core/qlm_pkg.sv =====
package qlm_pkg;
  localparam int NumResources = 16;
  localparam int NumClients   = 16;
  localparam int QueueDepth   = 8;
  localparam int ResW  = 4;
  localparam int CliW  = 4;
  localparam int SlotW = $clog2(QueueDepth);
  localparam int CntW  = $clog2(QueueDepth + 1);
  localparam int MemW  = $clog2(NumResources * QueueDepth);

  typedef enum logic [1:0] {
    FnLock   = 2'd0,
    FnUnlock = 2'd1,
    FnGone   = 2'd2,
    FnNone   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    KGrant    = 3'd0,
    KQueued   = 3'd1,
    KIgnored  = 3'd2,
    KRejected = 3'd3,
    KDone     = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    StIdle,
    StDecide,
    StPurgeRd,
    StPurgeChk,
    StPopRd,
    StPopWr,
    StEmit,
    StNext
  } state_e;

  typedef struct packed {
    logic [2:0]      kind;
    logic [CliW-1:0] grant_client;
    logic [ResW-1:0] grant_resource;
    logic            last;
  } result_t;

  typedef struct packed {
    logic [1:0]      func;
    logic [CliW-1:0] client;
    logic [ResW-1:0] resource;
    logic            vanished;
  } request_t;

  // queue memory access from the sequencer
  typedef struct packed {
    logic            we;
    logic [MemW-1:0] waddr;
    logic [CliW-1:0] wdata;
    logic [MemW-1:0] raddr;
  } qmem_req_t;
endpackage

// ===== rtl/core/qlm_if.sv =====
interface qlm_req_if;
  logic               valid;
  logic               ready;
  qlm_pkg::request_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface qlm_res_if;
  logic              valid;
  logic              ready;
  qlm_pkg::result_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/qlm_queue_mem.sv =====
module qlm_queue_mem (
  input  logic                            clk_i,
  input  qlm_pkg::qmem_req_t              req_i,
  output logic [qlm_pkg::CliW-1:0]        rdata_o
);
  logic [qlm_pkg::CliW-1:0] mem_q [qlm_pkg::NumResources*qlm_pkg::QueueDepth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) mem_q[req_i.waddr] <= req_i.wdata;
    rdata_o <= mem_q[req_i.raddr];
  end
endmodule

// ===== rtl/core/queued_lock_manager.sv =====
// queued lock manager: fifo-queued mutexes over 16 resources for 16 clients
// req channel (func, client, resource, vanished) is taken one beat at a time;
// ready is high only while the sequencer is idle and no result waits.
// lock, unlock and none give one result beat; an honoured client gone
// gives one grant beat per handed-over resource then a done beat, else
// one ignored beat; last marks the final beat. unlock with waiters moves
// each waiter up one slot (read, then write); client gone walks every
// resource, purging its queue slot by slot (read, then check and compact),
// then hands the resource on if it held it and waiters remain. all work
// goes through one queue memory port (one read, one write a cycle).
// result beats sit in one output register; the sequencer waits while the
// receiver stalls and resumes when the beat is taken.
// reset clears held, registered and wait counts at once; the queue memory
// and owners need no clearing, so the block is ready right after reset.
module queued_lock_manager (
  input  logic       clk_i,
  input  logic       rst_ni,
  qlm_req_if.sink    req_i,
  qlm_res_if.source  res_o
);
  localparam int RW = qlm_pkg::ResW;
  localparam int CW = qlm_pkg::CliW;

  qlm_pkg::state_e state_q, state_d;
  qlm_pkg::request_t req_q;
  logic [qlm_pkg::NumResources-1:0] held_q;
  logic [CW-1:0] owner_q [qlm_pkg::NumResources];
  logic [qlm_pkg::CntW-1:0] cnt_q [qlm_pkg::NumResources];
  logic [qlm_pkg::NumClients-1:0] reg_q;
  logic [RW-1:0] res_idx_q;          // resource under work
  logic [qlm_pkg::CntW-1:0] rd_q;    // read slot
  logic [qlm_pkg::CntW-1:0] wr_q;    // write slot (purge compaction)
  logic [CW-1:0] head_q;
  logic any_grant_q;
  logic out_v_q;
  qlm_pkg::result_t out_q;
  logic [CW-1:0] rdata;
  qlm_pkg::qmem_req_t mreq;

  qlm_queue_mem u_mem (.clk_i(clk_i), .req_i(mreq), .rdata_o(rdata));

  logic [qlm_pkg::CntW-1:0] cur_cnt;
  logic gone;
  assign cur_cnt = cnt_q[res_idx_q];
  assign gone = (req_q.func == qlm_pkg::FnGone);

  // pop reads slot 0 in the cycle before the first pop read
  logic pop_start;
  assign pop_start = (state_q == qlm_pkg::StNext) && held_q[res_idx_q]
                     && owner_q[res_idx_q] == req_q.client && wr_q != '0;

  function automatic logic [qlm_pkg::MemW-1:0] addr(logic [RW-1:0] r,
                                                   logic [qlm_pkg::CntW-1:0] s);
    return {r, s[qlm_pkg::SlotW-1:0]};
  endfunction

  assign req_i.ready = (state_q == qlm_pkg::StIdle) && !out_v_q;
  assign res_o.valid = out_v_q;
  assign res_o.payload = out_q;

  logic in_acc, out_free, emit;
  qlm_pkg::result_t emit_res;
  assign in_acc = req_i.valid && req_i.ready;
  assign out_free = !out_v_q || res_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      qlm_pkg::StIdle:   if (in_acc) state_d = qlm_pkg::StDecide;
      qlm_pkg::StDecide: begin
        if (out_free) begin
          if (gone && req_q.func != qlm_pkg::FnNone && reg_q[req_q.client]
              && req_q.vanished) state_d = qlm_pkg::StPurgeRd;
          else if (req_q.func == qlm_pkg::FnUnlock && held_q[req_q.resource]
              && owner_q[req_q.resource] == req_q.client
              && cnt_q[req_q.resource] != '0) state_d = qlm_pkg::StPopRd;
          else state_d = qlm_pkg::StIdle;
        end
      end
      qlm_pkg::StPurgeRd:
        state_d = (rd_q == cur_cnt) ? qlm_pkg::StNext : qlm_pkg::StPurgeChk;
      qlm_pkg::StPurgeChk: state_d = qlm_pkg::StPurgeRd;
      qlm_pkg::StNext: begin
        if (pop_start) state_d = qlm_pkg::StPopRd;
        else if (res_idx_q == RW'(qlm_pkg::NumResources-1)) state_d = qlm_pkg::StEmit;
        else state_d = qlm_pkg::StPurgeRd;
      end
      qlm_pkg::StPopRd:
        state_d = (rd_q == cur_cnt) ? qlm_pkg::StEmit : qlm_pkg::StPopWr;
      qlm_pkg::StPopWr: state_d = qlm_pkg::StPopRd;
      qlm_pkg::StEmit: begin
        if (out_free) begin
          if (gone && (any_grant_q || res_idx_q != RW'(qlm_pkg::NumResources-1)))
            state_d = (res_idx_q == RW'(qlm_pkg::NumResources-1))
                      ? qlm_pkg::StEmit : qlm_pkg::StPurgeRd;
          else state_d = qlm_pkg::StIdle;
        end
      end
      default: state_d = qlm_pkg::StIdle;
    endcase
  end

  // memory requests and result beats
  always_comb begin
    mreq = '0;
    emit = 1'b0;
    emit_res = '0;
    unique case (state_q)
      qlm_pkg::StDecide: begin
        emit = out_free;
        emit_res.grant_client = req_q.client;
        emit_res.grant_resource = req_q.resource;
        emit_res.last = 1'b1;
        emit_res.kind = qlm_pkg::KIgnored;
        if (req_q.func == qlm_pkg::FnNone) emit = out_free;
        else if (gone) begin
          emit = out_free && !(reg_q[req_q.client] && req_q.vanished);
        end else if (req_q.func == qlm_pkg::FnLock) begin
          if (!held_q[req_q.resource]) emit_res.kind = qlm_pkg::KGrant;
          else if (cnt_q[req_q.resource] >= qlm_pkg::CntW'(qlm_pkg::QueueDepth))
            emit_res.kind = qlm_pkg::KRejected;
          else begin
            emit_res.kind = qlm_pkg::KQueued;
            mreq.we = out_free;
            mreq.waddr = addr(req_q.resource, cnt_q[req_q.resource]);
            mreq.wdata = req_q.client;
          end
        end else if (held_q[req_q.resource] && owner_q[req_q.resource] == req_q.client) begin
          if (cnt_q[req_q.resource] == '0) emit_res.kind = qlm_pkg::KDone;
          else begin
            emit = 1'b0;
            mreq.raddr = addr(req_q.resource, '0);
          end
        end
      end
      qlm_pkg::StPurgeRd: mreq.raddr = addr(res_idx_q, rd_q);
      qlm_pkg::StPurgeChk: begin
        mreq.we = (rdata != req_q.client);
        mreq.waddr = addr(res_idx_q, wr_q);
        mreq.wdata = rdata;
      end
      qlm_pkg::StNext: mreq.raddr = addr(res_idx_q, '0);
      qlm_pkg::StPopRd: mreq.raddr = addr(res_idx_q, rd_q);
      qlm_pkg::StPopWr: begin
        mreq.we = 1'b1;
        mreq.waddr = addr(res_idx_q, rd_q - 1'b1);
        mreq.wdata = rdata;
      end
      qlm_pkg::StEmit: begin
        emit = out_free;
        if (gone && !(res_idx_q == RW'(qlm_pkg::NumResources-1) && !any_grant_q)) begin
          emit_res.kind = qlm_pkg::KGrant;
          emit_res.grant_client = head_q;
          emit_res.grant_resource = res_idx_q;
        end else if (gone) begin
          emit_res.kind = qlm_pkg::KDone;
          emit_res.grant_client = req_q.client;
          emit_res.last = 1'b1;
        end else begin
          emit_res.kind = qlm_pkg::KGrant;
          emit_res.grant_client = head_q;
          emit_res.grant_resource = res_idx_q;
          emit_res.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qlm_pkg::StIdle;
      out_v_q <= 1'b0;
      held_q <= '0;
      reg_q <= '0;
      any_grant_q <= 1'b0;
      for (int i = 0; i < qlm_pkg::NumResources; i++) cnt_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_v_q <= 1'b1;
        out_q <= emit_res;
      end else if (res_o.ready) out_v_q <= 1'b0;
      unique case (state_q)
        qlm_pkg::StIdle: if (in_acc) req_q <= req_i.payload;
        qlm_pkg::StDecide: if (out_free) begin
          res_idx_q <= gone ? '0 : req_q.resource;
          rd_q <= (req_q.func == qlm_pkg::FnUnlock && cnt_q[req_q.resource] != '0)
                  ? qlm_pkg::CntW'(1) : '0;
          wr_q <= '0;
          any_grant_q <= 1'b0;
          if (req_q.func == qlm_pkg::FnLock) begin
            if (!held_q[req_q.resource]) begin
              held_q[req_q.resource] <= 1'b1;
              owner_q[req_q.resource] <= req_q.client;
              reg_q[req_q.client] <= 1'b1;
            end else if (cnt_q[req_q.resource] < qlm_pkg::CntW'(qlm_pkg::QueueDepth)) begin
              cnt_q[req_q.resource] <= cnt_q[req_q.resource] + 1'b1;
              reg_q[req_q.client] <= 1'b1;
            end
          end else if (req_q.func == qlm_pkg::FnUnlock && held_q[req_q.resource]
                       && owner_q[req_q.resource] == req_q.client
                       && cnt_q[req_q.resource] == '0) begin
            held_q[req_q.resource] <= 1'b0;
            reg_q[req_q.client] <= 1'b0;
          end
        end
        qlm_pkg::StPurgeRd: if (rd_q != cur_cnt) rd_q <= rd_q + 1'b1;
        qlm_pkg::StPurgeChk: if (rdata != req_q.client) wr_q <= wr_q + 1'b1;
        qlm_pkg::StNext: begin
          cnt_q[res_idx_q] <= wr_q;
          rd_q <= pop_start ? qlm_pkg::CntW'(1) : '0;
          wr_q <= '0;
          if (held_q[res_idx_q] && owner_q[res_idx_q] == req_q.client && wr_q == '0)
            held_q[res_idx_q] <= 1'b0;
          if (!pop_start && res_idx_q != RW'(qlm_pkg::NumResources-1))
            res_idx_q <= res_idx_q + 1'b1;
        end
        qlm_pkg::StPopRd: begin
          if (rd_q == qlm_pkg::CntW'(1)) head_q <= rdata;
          if (rd_q == cur_cnt) begin
            cnt_q[res_idx_q] <= cur_cnt - 1'b1;
            owner_q[res_idx_q] <= (rd_q == qlm_pkg::CntW'(1)) ? rdata : head_q;
            any_grant_q <= 1'b1;
          end
        end
        qlm_pkg::StPopWr: rd_q <= rd_q + 1'b1;
        qlm_pkg::StEmit: if (out_free && gone) begin
          rd_q <= '0;
          wr_q <= '0;
          // a pending grant is consumed by this beat
          any_grant_q <= 1'b0;
          if (res_idx_q != RW'(qlm_pkg::NumResources-1)) res_idx_q <= res_idx_q + 1'b1;
          else if (!any_grant_q) reg_q[req_q.client] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !req_i.ready) else $error("ready while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !res_o.ready) |=> $stable(out_q)) else $error("beat changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_start |=> state_q == qlm_pkg::StPopRd) else $error("pop missed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qlm_pkg::StIdle) |-> !mreq.we) else $error("write while idle");
endmodule

// ===== sim/queued_lock_manager_tb.sv =====
`timescale 1ns / 100ps

module queued_lock_manager_tb;
  localparam int StallLimit = 5000;
  localparam int LongHold   = 300;

  logic clk_i;
  logic rst_ni;

  qlm_req_if req_if ();
  qlm_res_if res_if ();

  queued_lock_manager dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  // lock table mirror
  logic                     lk_held [qlm_pkg::NumResources];
  logic [qlm_pkg::CliW-1:0] lk_owner [qlm_pkg::NumResources];
  logic [qlm_pkg::CliW-1:0] lk_waiters [qlm_pkg::NumResources][$];
  logic                     cl_known [qlm_pkg::NumClients];

  qlm_pkg::request_t pending_reqs [$];
  qlm_pkg::result_t  due_results [$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_epoch;
  int seen_epoch;
  int hold_left;
  int mismatches;
  int req_beats;
  int res_beats;
  int quiet_cycles;
  int grants_seen;
  int gone_seen;
  logic req_taken;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic add_result(input qlm_pkg::kind_e k, input logic [qlm_pkg::CliW-1:0] c,
                            input logic [qlm_pkg::ResW-1:0] r, input logic l);
    qlm_pkg::result_t res;
    res.kind           = k;
    res.grant_client   = c;
    res.grant_resource = r;
    res.last           = l;
    due_results.push_back(res);
  endtask

  // apply one request to the mirror and queue up what it should produce
  task automatic predict_lock_op(input qlm_pkg::request_t q);
    logic [qlm_pkg::CliW-1:0] c;
    logic [qlm_pkg::ResW-1:0] r;
    logic [qlm_pkg::CliW-1:0] kept [$];
    c = q.client;
    r = q.resource;
    case (qlm_pkg::func_e'(q.func))
      qlm_pkg::FnLock: begin
        if (!lk_held[r]) begin
          lk_held[r]  = 1'b1;
          lk_owner[r] = c;
          cl_known[c] = 1'b1;
          add_result(qlm_pkg::KGrant, c, r, 1'b1);
        end else if (lk_waiters[r].size() >= qlm_pkg::QueueDepth) begin
          add_result(qlm_pkg::KRejected, c, r, 1'b1);
        end else begin
          lk_waiters[r].push_back(c);
          cl_known[c] = 1'b1;
          add_result(qlm_pkg::KQueued, c, r, 1'b1);
        end
      end
      qlm_pkg::FnUnlock: begin
        if (!lk_held[r] || lk_owner[r] != c) begin
          add_result(qlm_pkg::KIgnored, c, r, 1'b1);
        end else if (lk_waiters[r].size() == 0) begin
          lk_held[r]  = 1'b0;
          cl_known[c] = 1'b0;
          add_result(qlm_pkg::KDone, c, r, 1'b1);
        end else begin
          lk_owner[r] = lk_waiters[r].pop_front();
          add_result(qlm_pkg::KGrant, lk_owner[r], r, 1'b1);
        end
      end
      qlm_pkg::FnGone: begin
        if (!cl_known[c] || !q.vanished) begin
          add_result(qlm_pkg::KIgnored, c, r, 1'b1);
        end else begin
          for (int i = 0; i < qlm_pkg::NumResources; i++) begin
            kept = {};
            for (int j = 0; j < lk_waiters[i].size(); j++)
              if (lk_waiters[i][j] != c) kept.push_back(lk_waiters[i][j]);
            lk_waiters[i] = kept;
            if (lk_held[i] && lk_owner[i] == c) begin
              if (lk_waiters[i].size() == 0) begin
                lk_held[i] = 1'b0;
              end else begin
                lk_owner[i] = lk_waiters[i].pop_front();
                add_result(qlm_pkg::KGrant, lk_owner[i], qlm_pkg::ResW'(i), 1'b0);
              end
            end
          end
          cl_known[c] = 1'b0;
          add_result(qlm_pkg::KDone, c, '0, 1'b1);
        end
      end
      default: add_result(qlm_pkg::KIgnored, c, r, 1'b1);
    endcase
  endtask

  task automatic issue(input qlm_pkg::func_e f, input int c, input int r, input bit v);
    qlm_pkg::request_t q;
    q.func     = f;
    q.client   = qlm_pkg::CliW'(c);
    q.resource = qlm_pkg::ResW'(r);
    q.vanished = v;
    predict_lock_op(q);
    pending_reqs.push_back(q);
  endtask

  // mostly contended traffic on a few clients and resources
  task automatic issue_random();
    int pick, c, r;
    pick = $urandom_range(99);
    c = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(5);
    r = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(3);
    if (pick < 45) begin
      issue(qlm_pkg::FnLock, c, r, 1'($urandom_range(1)));
    end else if (pick < 82) begin
      if (lk_held[r] && $urandom_range(9) < 7) c = int'(lk_owner[r]);
      issue(qlm_pkg::FnUnlock, c, r, 1'($urandom_range(1)));
    end else if (pick < 95) begin
      issue(qlm_pkg::FnGone, c, r, $urandom_range(99) < 85);
    end else begin
      issue(qlm_pkg::FnNone, c, r, 1'($urandom_range(1)));
    end
  endtask

  // sender
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_if.valid || req_taken) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.valid   <= 1'b1;
          req_if.payload <= pending_reqs.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver, with a long hold-off whenever the epoch moves
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (seen_epoch != hold_epoch) begin
        seen_epoch = hold_epoch;
        hold_left  = LongHold;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    req_taken <= req_if.valid && req_if.ready;
    if (req_if.valid && req_if.ready) req_beats <= req_beats + 1;
  end

  // result checker
  always @(posedge clk_i) begin
    qlm_pkg::result_t want;
    qlm_pkg::result_t got;
    if (res_if.valid && res_if.ready) begin
      got = res_if.payload;
      res_beats <= res_beats + 1;
      if (got.kind == qlm_pkg::KGrant) grants_seen <= grants_seen + 1;
      if (got.kind == qlm_pkg::KDone) gone_seen <= gone_seen + 1;
      if (due_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("tb: unexpected result beat kind=%0d client=%0d res=%0d last=%0b",
                   got.kind, got.grant_client, got.grant_resource, got.last);
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("tb: mismatch exp k=%0d c=%0d r=%0d l=%0b got k=%0d c=%0d r=%0d l=%0b",
                     want.kind, want.grant_client, want.grant_resource, want.last,
                     got.kind, got.grant_client, got.grant_resource, got.last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    res_if.ready   = 1'b0;
    req_taken      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_epoch = 0;
    seen_epoch = 0;
    hold_left  = 0;
    mismatches = 0;
    req_beats  = 0;
    res_beats  = 0;
    quiet_cycles = 0;
    grants_seen  = 0;
    gone_seen    = 0;
    for (int i = 0; i < qlm_pkg::NumResources; i++) begin
      lk_held[i]  = 1'b0;
      lk_owner[i] = '0;
      lk_waiters[i] = {};
    end
    for (int i = 0; i < qlm_pkg::NumClients; i++) cl_known[i] = 1'b0;

    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: self queueing, full queue, ignores, client gone
    issue(qlm_pkg::FnLock, 0, 0, 1'b0);
    issue(qlm_pkg::FnLock, 0, 0, 1'b0);
    for (int c = 1; c <= 7; c++) issue(qlm_pkg::FnLock, c, 0, 1'b0);
    issue(qlm_pkg::FnLock, 8, 0, 1'b0);
    issue(qlm_pkg::FnUnlock, 5, 0, 1'b0);
    issue(qlm_pkg::FnUnlock, 15, 15, 1'b1);
    issue(qlm_pkg::FnNone, 15, 15, 1'b1);
    issue(qlm_pkg::FnGone, 9, 0, 1'b1);
    issue(qlm_pkg::FnGone, 0, 0, 1'b0);
    issue(qlm_pkg::FnLock, 0, 3, 1'b0);
    issue(qlm_pkg::FnLock, 4, 3, 1'b0);
    issue(qlm_pkg::FnGone, 0, 9, 1'b1);
    issue(qlm_pkg::FnLock, 15, 15, 1'b1);
    issue(qlm_pkg::FnUnlock, 15, 15, 1'b0);
    issue(qlm_pkg::FnUnlock, 1, 0, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      // pause until the block has drained
      wait (pending_reqs.size() == 0 && due_results.size() == 0);
      repeat (20) @(posedge clk_i);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      if (ph == 2) hold_epoch = hold_epoch + 1;
      for (int n = 0; n < 100; n++) issue_random();
    end

    wait (pending_reqs.size() == 0 && !req_if.valid);
    wait (due_results.size() == 0);
    repeat (700) @(posedge clk_i);

    $display("tb: %0d requests and %0d result beats (%0d grants, %0d done)",
             req_beats, res_beats, grants_seen, gone_seen);
    $display("tb: lock, unlock, client gone, full queues, long receiver hold-off");
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/qlm_pkg.sv
rtl/core/qlm_if.sv
rtl/core/qlm_queue_mem.sv
rtl/core/queued_lock_manager.sv
sim/queued_lock_manager_tb.sv
